// ===== hdl/qyfc_pkg.sv =====
// shared types, constants and the arctangent table for the yaw flip corrector
// used by every module of the block; depends on nothing
package qyfc_pkg;

	localparam int TRACKER_COUNT_DEF = 16;
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int ATAN_LEN          = 24;
	localparam int CNT_W             = 5;
	localparam int QUEUE_DEPTH       = 2;
	localparam int PROD_W            = 32;
	localparam int ACC_W             = 33;
	localparam int VEC_W             = 34;
	localparam int CORDIC_W          = 38;
	localparam int ANG_W             = 32;
	localparam int HEAD_W            = 16;
	localparam int IDX_W             = 4;

	localparam logic signed [VEC_W-1:0] Q28_ONE    = VEC_W'(64'sd268435456);
	localparam logic [ANG_W-1:0]        HALF_TURN  = 32'h8000_0000;
	localparam logic [ANG_W-1:0]        ROUND_HALF = 32'h0000_8000;
	localparam logic [HEAD_W-1:0]       HEAD_HALF  = 16'h8000;

	typedef struct packed {
		logic [IDX_W-1:0]         tracker_index;
		logic signed [HEAD_W-1:0] quat_w;
		logic signed [HEAD_W-1:0] quat_x;
		logic signed [HEAD_W-1:0] quat_y;
		logic signed [HEAD_W-1:0] quat_z;
	} sample_t;

	typedef struct packed {
		logic [IDX_W-1:0]         body_index;
		logic signed [HEAD_W-1:0] raw_heading;
		logic signed [HEAD_W-1:0] corrected_heading;
		logic                     was_flipped;
	} result_t;

	// vector handed from front to back, already turned into the right half plane
	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [VEC_W-1:0] s;
		logic signed [VEC_W-1:0] c;
		logic                    half;
		logic                    zero;
	} work_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_MUL,
		FE_PUSH
	} fe_state_t;

	typedef enum logic [1:0] {
		MS_WZ,
		MS_XY,
		MS_YY,
		MS_ZZ
	} mul_step_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROT,
		BK_DONE
	} bk_state_t;

	function automatic logic [ANG_W-1:0] atan_turn(input logic [CNT_W-1:0] i);
		logic [ANG_W-1:0] t;
		case (i)
			5'd0:    t = 32'h20000000;
			5'd1:    t = 32'h12E4051E;
			5'd2:    t = 32'h09FB385B;
			5'd3:    t = 32'h051111D4;
			5'd4:    t = 32'h028B0D43;
			5'd5:    t = 32'h0145D7E1;
			5'd6:    t = 32'h00A2F61E;
			5'd7:    t = 32'h00517C55;
			5'd8:    t = 32'h0028BE53;
			5'd9:    t = 32'h00145F2F;
			5'd10:   t = 32'h000A2F98;
			5'd11:   t = 32'h000517CC;
			5'd12:   t = 32'h00028BE6;
			5'd13:   t = 32'h000145F3;
			5'd14:   t = 32'h0000A2F9;
			5'd15:   t = 32'h0000517C;
			5'd16:   t = 32'h000028BE;
			5'd17:   t = 32'h0000145F;
			5'd18:   t = 32'h00000A2F;
			5'd19:   t = 32'h00000517;
			5'd20:   t = 32'h0000028B;
			5'd21:   t = 32'h00000145;
			5'd22:   t = 32'h000000A2;
			5'd23:   t = 32'h00000051;
			default: t = '0;
		endcase
		return t;
	endfunction

	// magnitude of a wrapped 16-bit angle, the most negative value counts as a half turn
	function automatic logic [HEAD_W:0] abs_head(input logic [HEAD_W-1:0] a);
		logic signed [HEAD_W:0] v;
		v = {a[HEAD_W-1], a};
		return v[HEAD_W] ? (HEAD_W+1)'(-v) : (HEAD_W+1)'(v);
	endfunction

endpackage

// ===== hdl/qyfc_stream_if.sv =====
// valid/ready channel carrying one item of a chosen payload type
// no dependencies; the payload type is set where the channel is instantiated
interface qyfc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/quaternion_yaw_flip_corrector_top.sv =====
// the number of cordic steps used is capped at 24
// throughput is set by the back's iterative cordic, which works on one item at a time; the front
// forms each vector on its single shared multiplier and can take a new sample while the back rotates
// reset: arst_n clears all control state and every tracker's prior flag at once
// top level: front, queue and back; depends on qyfc_pkg, qyfc_stream_if and the three parts
module quaternion_yaw_flip_corrector_top #(
	parameter int TRACKER_COUNT = qyfc_pkg::TRACKER_COUNT_DEF,
	parameter int CORDIC_STEPS  = qyfc_pkg::CORDIC_STEPS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	qyfc_stream_if.sink   sample,
	qyfc_stream_if.source result
);
	import qyfc_pkg::*;

	work_t push_data, pop_data;
	logic push_valid, push_ready, pop_valid, pop_ready;

	qyfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	qyfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	qyfc_back #(
		.TRACKER_COUNT (TRACKER_COUNT),
		.CORDIC_STEPS  (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.result    (result)
	);

endmodule

// ===== hdl/qyfc_front.sv =====
// front part: takes a quaternion sample, forms the yaw vector with one shared multiplier
// and pushes it into the queue; depends on qyfc_pkg and qyfc_stream_if
module qyfc_front (
	input  logic            clk,
	input  logic            arst_n,
	qyfc_stream_if.sink     sample,
	output qyfc_pkg::work_t push_data,
	output logic            push_valid,
	input  logic            push_ready
);
	import qyfc_pkg::*;

	fe_state_t state_q, state_d;
	mul_step_t step_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [HEAD_W-1:0] w_q, x_q, y_q, z_q;
	logic signed [HEAD_W-1:0] op_a, op_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_s_q, acc_c_q;
	logic signed [VEC_W-1:0] s_full, c_full;
	logic take, mul_en;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FE_IDLE: begin
				if (sample.valid) state_d = FE_MUL;
			end
			FE_MUL: begin
				if (step_q == MS_ZZ) state_d = FE_PUSH;
			end
			FE_PUSH: begin
				if (push_ready) state_d = FE_IDLE;
			end
			default: state_d = FE_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = (state_q == FE_IDLE);
		push_valid   = (state_q == FE_PUSH);
		mul_en       = (state_q == FE_MUL);
		take         = (state_q == FE_IDLE) && sample.valid;
	end

	always_comb begin
		case (step_q)
			MS_WZ: begin
				op_a = w_q;
				op_b = z_q;
			end
			MS_XY: begin
				op_a = x_q;
				op_b = y_q;
			end
			MS_YY: begin
				op_a = y_q;
				op_b = y_q;
			end
			MS_ZZ: begin
				op_a = z_q;
				op_b = z_q;
			end
			default: begin
				op_a = w_q;
				op_b = z_q;
			end
		endcase
	end

	assign prod = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			step_q  <= MS_WZ;
		end else begin
			state_q <= state_d;
			if (take) begin
				step_q <= MS_WZ;
			end else if (mul_en) begin
				case (step_q)
					MS_WZ:   step_q <= MS_XY;
					MS_XY:   step_q <= MS_YY;
					MS_YY:   step_q <= MS_ZZ;
					default: step_q <= MS_WZ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q <= sample.payload.tracker_index;
			w_q   <= sample.payload.quat_w;
			x_q   <= sample.payload.quat_x;
			y_q   <= sample.payload.quat_y;
			z_q   <= sample.payload.quat_z;
		end
		if (mul_en) begin
			case (step_q)
				MS_WZ:   acc_s_q <= ACC_W'(prod);
				MS_XY:   acc_s_q <= acc_s_q + ACC_W'(prod);
				MS_YY:   acc_c_q <= ACC_W'(prod);
				default: acc_c_q <= acc_c_q + ACC_W'(prod);
			endcase
		end
	end

	// s = 2(wz+xy), c = 1 - 2(yy+zz) in units of 2^-28
	always_comb begin
		s_full = {acc_s_q, 1'b0};
		c_full = Q28_ONE - $signed({acc_c_q, 1'b0});
		push_data.idx  = idx_q;
		push_data.half = c_full[VEC_W-1];
		push_data.zero = (s_full == '0) && (c_full == '0);
		push_data.s    = c_full[VEC_W-1] ? -s_full : s_full;
		push_data.c    = c_full[VEC_W-1] ? -c_full : c_full;
	end

endmodule

// ===== hdl/qyfc_queue.sv =====
// short queue of yaw vectors between the front and the back
// depends on qyfc_pkg
module qyfc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  qyfc_pkg::work_t push_data,
	input  logic            push_valid,
	output logic            push_ready,
	output qyfc_pkg::work_t pop_data,
	output logic            pop_valid,
	input  logic            pop_ready
);
	import qyfc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	work_t slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != CNT_QW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== hdl/qyfc_back.sv =====
// back part: iterative cordic atan2, then the half-turn choice against per-tracker state
// depends on qyfc_pkg and qyfc_stream_if
module qyfc_back #(
	parameter int TRACKER_COUNT = qyfc_pkg::TRACKER_COUNT_DEF,
	parameter int CORDIC_STEPS  = qyfc_pkg::CORDIC_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  qyfc_pkg::work_t pop_data,
	input  logic            pop_valid,
	output logic            pop_ready,
	qyfc_stream_if.source   result
);
	import qyfc_pkg::*;

	localparam int DEPTH     = (TRACKER_COUNT < 16) ? TRACKER_COUNT : 16;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int STEPS_EFF = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

	bk_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic signed [CORDIC_W-1:0] s_q, c_q, sh_s, sh_c, s_nx, c_nx;
	logic [ANG_W-1:0] ang_q, ang_nx, ang_rnd;
	logic [IDX_W-1:0] idx_q;
	logic zero_q;

	logic [HEAD_W-1:0] heading_mem [DEPTH];
	logic [HEAD_W-1:0] prev_q;
	logic [DEPTH-1:0] prior_q;

	logic [AW-1:0] rd_addr, wr_addr;
	logic in_range, prior, flip, out_free, load_out, take, rotate, last_step;
	logic [HEAD_W-1:0] raw, corr, diff, diff_f;

	result_t res_q;
	logic res_valid_q;

	assign last_step = (cnt_q == CNT_W'(STEPS_EFF - 1));
	assign out_free  = !res_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) state_d = BK_ROT;
			end
			BK_ROT: begin
				if (last_step) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = (state_q == BK_IDLE);
		take      = (state_q == BK_IDLE) && pop_valid;
		rotate    = (state_q == BK_ROT);
		load_out  = (state_q == BK_DONE) && out_free;
	end

	// one micro-rotation
	always_comb begin
		sh_s = s_q >>> cnt_q;
		sh_c = c_q >>> cnt_q;
		if (!s_q[CORDIC_W-1]) begin
			c_nx   = c_q + sh_s;
			s_nx   = s_q - sh_c;
			ang_nx = ang_q + atan_turn(cnt_q);
		end else begin
			c_nx   = c_q - sh_s;
			s_nx   = s_q + sh_c;
			ang_nx = ang_q - atan_turn(cnt_q);
		end
	end

	// half-turn choice
	always_comb begin
		rd_addr  = pop_data.idx[AW-1:0];
		wr_addr  = idx_q[AW-1:0];
		in_range = ({1'b0, idx_q} < (IDX_W+1)'(DEPTH));
		prior    = in_range && prior_q[wr_addr];
		ang_rnd  = ang_q + ROUND_HALF;
		raw      = zero_q ? '0 : ang_rnd[ANG_W-1:ANG_W-HEAD_W];
		diff     = raw - prev_q;
		diff_f   = diff + HEAD_HALF;
		flip     = prior && !(abs_head(diff) < abs_head(diff_f));
		corr     = flip ? raw + HEAD_HALF : raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cnt_q       <= '0;
			prior_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				cnt_q <= '0;
			end else if (rotate) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (load_out && in_range) prior_q[wr_addr] <= 1'b1;
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s_q    <= CORDIC_W'(pop_data.s);
			c_q    <= CORDIC_W'(pop_data.c);
			ang_q  <= pop_data.half ? HALF_TURN : '0;
			idx_q  <= pop_data.idx;
			zero_q <= pop_data.zero;
		end else if (rotate) begin
			s_q   <= s_nx;
			c_q   <= c_nx;
			ang_q <= ang_nx;
		end
		if (load_out) begin
			res_q.body_index        <= idx_q;
			res_q.raw_heading       <= raw;
			res_q.corrected_heading <= corr;
			res_q.was_flipped       <= flip;
		end
	end

	always_ff @(posedge clk) begin
		if (take) prev_q <= heading_mem[rd_addr];
		if (load_out && in_range) heading_mem[wr_addr] <= corr;
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

endmodule
